// File: rtl/lss_pkg.sv
// Shared types and constants for the LIFO stack with statistics.
// Used by the front end, the back end and the top level; no dependencies.
package lss_pkg;

    // Default stack depth and fixed field widths
    localparam int DEPTH_DEF   = 64;
    localparam int DATA_W      = 32;
    localparam int RES_W       = 64;
    localparam int CMD_W       = 3;
    localparam int S_TDATA_W   = 40;   // cmd + value, padded to whole bytes
    localparam int M_TDATA_W   = 64;
    localparam int QUEUE_DEPTH = 2;

    // Average is scaled to hundredths
    localparam int AVG_SCALE   = 100;
    localparam int PROD_W      = 39;   // signed total * 100
    localparam int MAG_W       = 38;   // magnitude of that product

    // Command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH    = 3'd0,
        CMD_POP     = 3'd1,
        CMD_PRINT   = 3'd2,
        CMD_SUM     = 3'd3,
        CMD_SQUARES = 3'd4,
        CMD_AVG     = 3'd5,
        CMD_PEEK    = 3'd6
    } op_t;

    // Classified command word passed from front to back
    typedef struct packed {
        op_t                      op;
        logic signed [DATA_W-1:0] value;
    } cmd_t;

endpackage

// File: rtl/lss_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

// File: rtl/lss_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on nothing; widths come from parameters.
module lss_div #(
    parameter int NUM_W = 38,
    parameter int DEN_W = 7
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quot,
    output logic [DEN_W-1:0] rem
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] quot_reg, quot_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;

    // One shift-subtract step
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        trial     = {rem_reg, quot_reg[NUM_W-1]};
        diff      = trial - {1'b0, den_reg};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W);
            quot_next = num;
            rem_next  = '0;
            den_next  = den;
        end else if (busy_reg) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_next  = diff[DEN_W-1:0];
                quot_next = {quot_reg[NUM_W-2:0], 1'b1};
            end else begin
                rem_next  = trial[DEN_W-1:0];
                quot_next = {quot_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg  <= cnt_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg;

endmodule

// File: rtl/lss_front.sv
// Front end: accepts input words, decodes the command and queues them.
// Depends on lss_pkg.
module lss_front (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [lss_pkg::S_TDATA_W-1:0]    s_tdata,   // [2:0] cmd, [34:3] value
    output logic                             q_valid,
    output lss_pkg::cmd_t                    q_item,
    input  logic                             q_pop
);

    import lss_pkg::*;

    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t              q_mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [CMD_W-1:0]  cmd_raw;
    cmd_t              in_item;
    logic              do_push, do_pop;

    // Decode; the unused code behaves as average
    always_comb begin
        cmd_raw       = s_tdata[CMD_W-1:0];
        in_item.value = s_tdata[CMD_W +: DATA_W];
        if (cmd_raw > CMD_PEEK) begin
            in_item.op = CMD_AVG;
        end else begin
            in_item.op = op_t'(cmd_raw);
        end
    end

    assign s_tready = (fill_reg != FILL_W'(QUEUE_DEPTH));
    assign q_valid  = (fill_reg != '0);
    assign q_item   = q_mem_reg[rd_ptr_reg];
    assign do_push  = s_tvalid && s_tready;
    assign do_pop   = q_pop && q_valid;

    // Queue pointers and fill level
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
        if (do_push) begin
            q_mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// File: rtl/lss_back.sv
// Back end: executes queued commands on the stack RAM and drives results.
// Depends on lss_pkg, lss_ram and lss_div.
module lss_back #(
    parameter int DEPTH = lss_pkg::DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    input  lss_pkg::cmd_t                 q_item,
    output logic                          q_pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [lss_pkg::M_TDATA_W-1:0] m_tdata,   // [63:0] result
    output logic [0:0]                    m_tuser,   // [0] empty_res
    output logic                          m_tlast,
    output logic [$clog2(DEPTH+1)-1:0]    entry_count
);

    import lss_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_POPW  = 6'b000010,
        S_FETCH = 6'b000100,
        S_AVG   = 6'b001000,
        S_DIVW  = 6'b010000,
        S_EMIT  = 6'b100000
    } state_t;

    state_t                    state_reg, state_next;
    logic [CW-1:0]             count_reg, count_next;
    logic [DATA_W-1:0]         total_reg, total_next;
    op_t                       op_reg, op_next;
    logic [CW-1:0]             idx_reg, idx_next;
    logic signed [PROD_W-1:0]  num_reg, num_next;
    logic [RES_W-1:0]          res_reg, res_next;
    logic                      res_empty_reg, res_empty_next;
    logic                      res_last_reg, res_last_next;
    logic                      m_valid_reg, m_valid_next;
    logic [RES_W-1:0]          m_data_reg, m_data_next;
    logic                      m_empty_reg, m_empty_next;
    logic                      m_last_reg, m_last_next;

    // RAM and divider hookup
    logic              wr_en, rd_en;
    logic [AW-1:0]     rd_addr;
    logic [DATA_W-1:0] rd_data;
    logic              div_start, div_done;
    logic [MAG_W-1:0]  div_num, div_quot;
    logic [CW-1:0]     div_rem;

    // Datapath helpers
    logic [CW-1:0]     count_m1, idx_p1;
    logic              full, empty, out_free;
    logic [PROD_W-1:0] tot_ext, num_mag;
    logic [DATA_W-1:0] sq_mag;
    logic [RES_W-1:0]  sq_prod, rd_ext, tot_sext;
    logic [CW:0]       rem_x2;
    logic [MAG_W:0]    q_rnd;

    lss_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (q_item.value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    lss_div #(
        .NUM_W (MAG_W),
        .DEN_W (CW)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (count_reg),
        .done    (div_done),
        .quot    (div_quot),
        .rem     (div_rem)
    );

    // Arithmetic around the stack
    always_comb begin
        count_m1 = count_reg - 1'b1;
        idx_p1   = idx_reg + 1'b1;
        full     = (count_reg == CW'(DEPTH));
        empty    = (count_reg == '0);
        out_free = !m_valid_reg || m_tready;
        tot_ext  = {{(PROD_W - DATA_W){total_reg[DATA_W-1]}}, total_reg};
        tot_sext = {{(RES_W - DATA_W){total_reg[DATA_W-1]}}, total_reg};
        rd_ext   = {{(RES_W - DATA_W){rd_data[DATA_W-1]}}, rd_data};
        sq_mag   = rd_data[DATA_W-1] ? (~rd_data + 1'b1) : rd_data;
        sq_prod  = RES_W'(sq_mag) * RES_W'(sq_mag);
        num_mag  = num_reg[PROD_W-1] ? (~num_reg + 1'b1) : num_reg;
        div_num  = num_mag[MAG_W-1:0];
        // round half away from zero on the magnitude
        rem_x2   = {div_rem, 1'b0};
        q_rnd    = {1'b0, div_quot} + ((rem_x2 >= {1'b0, count_reg}) ? 1'b1 : 1'b0);
    end

    // Command sequencer
    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        total_next     = total_reg;
        op_next        = op_reg;
        idx_next       = idx_reg;
        num_next       = num_reg;
        res_next       = res_reg;
        res_empty_next = res_empty_reg;
        res_last_next  = res_last_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        m_empty_next   = m_empty_reg;
        m_last_next    = m_last_reg;
        q_pop          = 1'b0;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = '0;
        div_start      = 1'b0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (q_valid) begin
                    q_pop   = 1'b1;
                    op_next = q_item.op;
                    case (q_item.op)
                        CMD_PUSH: begin
                            // dropped when full
                            if (!full) begin
                                wr_en      = 1'b1;
                                count_next = count_reg + 1'b1;
                                total_next = total_reg + q_item.value;
                            end
                        end
                        CMD_POP: begin
                            // top word is read back to take it off the total
                            if (!empty) begin
                                rd_en      = 1'b1;
                                rd_addr    = count_m1[AW-1:0];
                                state_next = S_POPW;
                            end
                        end
                        default: begin
                            res_empty_next = 1'b0;
                            res_last_next  = 1'b1;
                            if (empty) begin
                                res_next       = '0;
                                res_empty_next = 1'b1;
                                state_next     = S_EMIT;
                            end else begin
                                case (q_item.op)
                                    CMD_SUM: begin
                                        res_next   = tot_sext;
                                        state_next = S_EMIT;
                                    end
                                    CMD_PEEK: begin
                                        rd_en      = 1'b1;
                                        rd_addr    = count_m1[AW-1:0];
                                        state_next = S_FETCH;
                                    end
                                    CMD_PRINT, CMD_SQUARES: begin
                                        idx_next   = '0;
                                        rd_en      = 1'b1;
                                        rd_addr    = '0;
                                        state_next = S_FETCH;
                                    end
                                    default: begin
                                        num_next   = tot_ext * PROD_W'(AVG_SCALE);
                                        state_next = S_AVG;
                                    end
                                endcase
                            end
                        end
                    endcase
                end
            end
            S_POPW: begin
                total_next = total_reg - rd_data;
                count_next = count_m1;
                state_next = S_IDLE;
            end
            S_FETCH: begin
                res_next       = (op_reg == CMD_SQUARES) ? sq_prod : rd_ext;
                res_empty_next = 1'b0;
                res_last_next  = !(op_reg inside {CMD_PRINT, CMD_SQUARES})
                                 || (idx_p1 == count_reg);
                state_next     = S_EMIT;
            end
            S_AVG: begin
                div_start  = 1'b1;
                state_next = S_DIVW;
            end
            S_DIVW: begin
                if (div_done) begin
                    res_next   = num_reg[PROD_W-1] ? (~RES_W'(q_rnd) + 1'b1) : RES_W'(q_rnd);
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    m_empty_next = res_empty_reg;
                    m_last_next  = res_last_reg;
                    if (res_last_reg) begin
                        state_next = S_IDLE;
                    end else begin
                        idx_next   = idx_p1;
                        rd_en      = 1'b1;
                        rd_addr    = idx_p1[AW-1:0];
                        state_next = S_FETCH;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            total_reg   <= total_next;
            m_valid_reg <= m_valid_next;
        end
        op_reg        <= op_next;
        idx_reg       <= idx_next;
        num_reg       <= num_next;
        res_reg       <= res_next;
        res_empty_reg <= res_empty_next;
        res_last_reg  <= res_last_next;
        m_data_reg    <= m_data_next;
        m_empty_reg   <= m_empty_next;
        m_last_reg    <= m_last_next;
    end

    assign m_tvalid    = m_valid_reg;
    assign m_tdata     = m_data_reg;
    assign m_tuser     = m_empty_reg;
    assign m_tlast     = m_last_reg;
    assign entry_count = count_reg;

endmodule

// File: rtl/lifo_stack_with_stats_unit.sv
// LIFO stack of signed 32-bit words with print, sum, squares, average
// and peek. Top level; depends on lss_pkg, lss_front and lss_back.
//
// Input stream (s_): one word per command, tdata = {value, cmd}. Push and
// pop give no result; a push on a full stack and a pop on an empty one
// are dropped. Print and squares give one result per entry, bottom to
// top, with tlast on the top entry; sum, average and peek give one.
// On an empty stack every reporting command gives a single zero result
// with tuser (empty flag) and tlast set.
// Output stream (m_): tdata is the 64-bit signed result.
// Timing: a two-word queue decouples the input from the executing back
// end. The back end does a push in its idle state, reads the RAM for
// pop, peek, print and squares, and runs average through the 38-step
// bit-serial divider. A result sits in an
// output register until taken; while the receiver stalls the back end
// holds and the queue fills, then s_tready drops.
// Reset (aresetn low, synchronous) empties the stack and the queue; the
// stack RAM is not cleared, since entries above the count are never read.
module lifo_stack_with_stats_unit #(
    parameter int DEPTH = lss_pkg::DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [lss_pkg::S_TDATA_W-1:0] s_tdata,   // [2:0] cmd, [34:3] value
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [lss_pkg::M_TDATA_W-1:0] m_tdata,   // [63:0] result
    output logic [0:0]                    m_tuser,   // [0] empty_res
    output logic                          m_tlast
);

    import lss_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    logic          q_valid;
    logic          q_pop;
    cmd_t          q_item;
    logic [CW-1:0] entry_count;

    lss_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    lss_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .entry_count (entry_count)
    );

    // An empty-stack result is zero and closes its run
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> (m_tdata == '0) && m_tlast)
        else $error("empty result not zero or not last");

    // Fill level never passes the depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        entry_count <= CW'(DEPTH))
        else $error("entry count above depth");

    // Fill level moves by at most one per cycle
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> (entry_count == $past(entry_count))
              || (entry_count == CW'($past(entry_count) + 1'b1))
              || (entry_count == CW'($past(entry_count) - 1'b1)))
        else $error("entry count jumped");

endmodule

// File: bench/lifo_stack_with_stats_unit_test.sv
// Self-checking bench for the LIFO stack with print, sum, squares, average, peek.
// Depends on lss_pkg and lifo_stack_with_stats_unit; drives random commands with
// random stalls on both streams and checks every result word in order.
`timescale 1ns / 100ps

module lifo_stack_with_stats_unit_test;
    import lss_pkg::*;

    localparam int STACK_DEPTH  = DEPTH_DEF;
    localparam int PAD_W        = S_TDATA_W - CMD_W - DATA_W;
    localparam int ROUND_FACTOR = 2;
    localparam int IDLE_PCT     = 28;
    localparam int SETTLE_CYCLES = 80;     // lets the back end and queue settle
    localparam int STALL_LIMIT  = 4000;    // cycles with no word moving

    // Expected result word
    typedef struct packed {
        logic [RES_W-1:0] res;
        logic             empty;
        logic             last;
    } stack_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;   // [2:0] cmd, [34:3] value
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;        // [63:0] result
    logic [0:0]           m_tuser;        // [0] empty_res
    logic                 m_tlast;

    // Shadow copy of the stack
    logic [DATA_W-1:0]    shadow_words [STACK_DEPTH];
    int                   shadow_count = 0;
    logic [DATA_W-1:0]    shadow_total = '0;

    stack_result_t        pending_results [$];
    int                   error_count = 0;
    int                   quiet_cycles = 0;
    bit                   src_idle_on = 1'b1;
    bit                   sink_idle_on = 1'b1;

    lifo_stack_with_stats_unit #(
        .DEPTH (STACK_DEPTH)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // 100 MHz clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic logic [RES_W-1:0] widen(logic [DATA_W-1:0] w);
        return {{(RES_W-DATA_W){w[DATA_W-1]}}, w};
    endfunction

    function automatic logic [RES_W-1:0] square_word(logic [DATA_W-1:0] w);
        logic signed [RES_W-1:0] s;
        logic [RES_W-1:0]        mag;
        s   = widen(w);
        mag = (s < 0) ? -s : s;
        return mag * mag;
    endfunction

    // total * 100 / count, rounded half away from zero
    function automatic logic [RES_W-1:0] average_hundredths();
        logic signed [RES_W-1:0] num;
        logic [RES_W-1:0]        mag;
        logic [RES_W-1:0]        cnt;
        logic [RES_W-1:0]        quo;
        logic [RES_W-1:0]        rem;
        num = $signed(widen(shadow_total)) * AVG_SCALE;
        mag = (num < 0) ? -num : num;
        cnt = RES_W'(shadow_count);
        quo = mag / cnt;
        rem = mag % cnt;
        if (rem * ROUND_FACTOR >= cnt) begin
            quo = quo + 1'b1;
        end
        return (num < 0) ? -quo : quo;
    endfunction

    // Update the shadow stack for one accepted word and queue its results
    task automatic predict_stack_op(op_t op, logic [DATA_W-1:0] val);
        stack_result_t r;
        r.empty = 1'b0;
        r.last  = 1'b1;
        case (op)
            CMD_PUSH: begin
                if (shadow_count < STACK_DEPTH) begin
                    shadow_words[shadow_count] = val;
                    shadow_count++;
                    shadow_total += val;
                end
            end
            CMD_POP: begin
                if (shadow_count > 0) begin
                    shadow_count--;
                    shadow_total -= shadow_words[shadow_count];
                end
            end
            default: begin
                if (shadow_count == 0) begin
                    r.res   = '0;
                    r.empty = 1'b1;
                    pending_results.push_back(r);
                end else if (op == CMD_PRINT || op == CMD_SQUARES) begin
                    for (int i = 0; i < shadow_count; i++) begin
                        r.res  = (op == CMD_PRINT) ? widen(shadow_words[i])
                                                   : square_word(shadow_words[i]);
                        r.last = (i + 1 == shadow_count);
                        pending_results.push_back(r);
                    end
                end else begin
                    case (op)
                        CMD_SUM:  r.res = widen(shadow_total);
                        CMD_PEEK: r.res = widen(shadow_words[shadow_count-1]);
                        default:  r.res = average_hundredths();
                    endcase
                    pending_results.push_back(r);
                end
            end
        endcase
    endtask

    // Send one command word; returns at the edge where it was taken
    task automatic send_word(op_t op, logic [DATA_W-1:0] val);
        if (src_idle_on) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{PAD_W{1'b0}}, val, op};
        do @(posedge aclk); while (!s_tready);
        predict_stack_op(op, val);
    endtask

    function automatic logic [DATA_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2, 3:    return $urandom_range(0, 200) - 100;
            default: return $urandom;
        endcase
    endfunction

    function automatic op_t pick_op(int push_pct, int pop_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < push_pct) begin
            return CMD_PUSH;
        end else if (r < push_pct + pop_pct) begin
            return CMD_POP;
        end
        case ($urandom_range(0, 4))
            0:       return CMD_PRINT;
            1:       return CMD_SUM;
            2:       return CMD_SQUARES;
            3:       return CMD_AVG;
            default: return CMD_PEEK;
        endcase
    endfunction

    // Hold the sender until every queued result is back, then let the back end settle
    task automatic wait_results_drained();
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic clear_stack();
        while (shadow_count > 0) send_word(CMD_POP, pick_word());
    endtask

    // Every reporting command on an empty stack, plus a pop that must be ignored
    task automatic test_empty_stack();
        send_word(CMD_POP, 32'hFFFF_FFFF);
        send_word(CMD_PRINT, 32'h0);
        send_word(CMD_SQUARES, 32'h0);
        send_word(CMD_SUM, 32'h0);
        send_word(CMD_AVG, 32'h0);
        send_word(CMD_PEEK, 32'h0);
    endtask

    // Most negative, most positive and -1; the sum comes to -2
    task automatic test_extreme_words();
        send_word(CMD_PUSH, 32'h8000_0000);
        send_word(CMD_PUSH, 32'h7FFF_FFFF);
        send_word(CMD_PUSH, 32'hFFFF_FFFF);
        send_word(CMD_PEEK, 32'h0);
        send_word(CMD_SUM, 32'h0);
        send_word(CMD_AVG, 32'h0);
        send_word(CMD_PRINT, 32'h0);
        send_word(CMD_SQUARES, 32'h0);
        clear_stack();
    endtask

    // Eight entries with total +1 and -1: 12.5 and -12.5 round away from zero
    task automatic test_rounding_ties();
        repeat (6) send_word(CMD_PUSH, 32'h0);
        send_word(CMD_PUSH, 32'h1);
        send_word(CMD_PUSH, 32'h0);
        send_word(CMD_AVG, 32'h0);
        send_word(CMD_POP, 32'h0);
        send_word(CMD_POP, 32'h0);
        send_word(CMD_PUSH, 32'hFFFF_FFFF);
        send_word(CMD_PUSH, 32'h0);
        send_word(CMD_AVG, 32'h0);
        clear_stack();
    endtask

    // Fill to depth, push past full, report, then pop past empty
    task automatic test_fill_and_overflow();
        while (shadow_count < STACK_DEPTH) send_word(CMD_PUSH, pick_word());
        repeat (3) send_word(CMD_PUSH, pick_word());
        send_word(CMD_PEEK, pick_word());
        send_word(CMD_SUM, pick_word());
        send_word(CMD_AVG, pick_word());
        send_word(CMD_PRINT, pick_word());
        send_word(CMD_SQUARES, pick_word());
        clear_stack();
        repeat (2) send_word(CMD_POP, pick_word());
        send_word(CMD_PEEK, pick_word());
    endtask

    // Random command mix; optionally stop once midway until all results are back
    task automatic test_random_mix(int n_words, int push_pct, int pop_pct, bit pause_mid);
        for (int i = 0; i < n_words; i++) begin
            if (pause_mid && i == n_words / 2) begin
                s_tvalid <= 1'b0;
                wait_results_drained();
            end
            send_word(pick_op(push_pct, pop_pct), pick_word());
        end
    endtask

    // Receiver stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= sink_idle_on ? ($urandom_range(0, 99) >= IDLE_PCT) : 1'b1;
        end
    end

    // Compare each result word against the oldest expectation
    always @(posedge aclk) begin
        stack_result_t want;
        stack_result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{res: m_tdata, empty: m_tuser[0], last: m_tlast};
            if (pending_results.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result res=%h empty=%b last=%b",
                         $time, got.res, got.empty, got.last);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    error_count++;
                    $display({"%0t: mismatch expected res=%h empty=%b last=%b,",
                              " got res=%h empty=%b last=%b"},
                             $time, want.res, want.empty, want.last,
                             got.res, got.empty, got.last);
                end
            end
        end
    end

    // Watchdog on cycles where no word moves on either stream
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no traffic for %0d cycles", $time, STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Test sequence
    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_stack();
        test_extreme_words();
        test_rounding_ties();
        test_fill_and_overflow();
        test_random_mix(90, 45, 20, 1'b1);

        // no stalls on either side for a stretch
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        test_random_mix(80, 45, 20, 1'b0);
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;

        test_random_mix(60, 30, 35, 1'b0);
        clear_stack();
        send_word(CMD_POP, pick_word());
        send_word(CMD_SUM, pick_word());
        s_tvalid <= 1'b0;

        wait_results_drained();
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
